// File: rtl/core/fmpe_pkg.sv
// shared constants and codes of the framed manchester packet encoder
package fmpe_pkg;

   localparam int TypeWidth   = 2;
   localparam int LengthWidth = 32;
   localparam int ByteWidth   = 8;
   localparam int SymWidth    = 2;

   // header cells: type bits then length bits
   localparam int HdrCells  = TypeWidth + LengthWidth;
   localparam int CntWidth  = $clog2(HdrCells + 1);

   typedef logic [SymWidth-1:0]    symbol_type;
   typedef logic [HdrCells-1:0]    cells_type;
   typedef logic [CntWidth-1:0]    cell_cnt_type;
   typedef logic [LengthWidth-1:0] length_type;

   // item kinds
   localparam logic KIND_HEADER  = 1'b0;
   localparam logic KIND_PAYLOAD = 1'b1;

   // line symbols
   localparam symbol_type SYM_START = 2'd0;
   localparam symbol_type SYM_ZERO  = 2'd1;
   localparam symbol_type SYM_ONE   = 2'd2;
   localparam symbol_type SYM_STOP  = 2'd3;

endpackage

// File: rtl/core/fmpe_ifs.sv
// valid/ready channel interfaces of the framed manchester packet encoder
interface fmpe_req_if;
   logic                               valid;
   logic                               ready;
   logic                               kind;
   logic [fmpe_pkg::TypeWidth-1:0]     frame_type;
   logic [fmpe_pkg::LengthWidth-1:0]   payload_length;
   logic [fmpe_pkg::ByteWidth-1:0]     payload_byte;

   modport source (output valid, kind, frame_type, payload_length, payload_byte,
                   input ready);
   modport sink   (input valid, kind, frame_type, payload_length, payload_byte,
                   output ready);
endinterface

interface fmpe_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [fmpe_pkg::SymWidth-1:0]   symbol;
   logic                            last;

   modport source (output valid, symbol, last, input ready);
   modport sink   (input valid, symbol, last, output ready);
endinterface

// File: rtl/core/framed_manchester_packet_encoder_top.sv
// top level of the framed manchester packet encoder
//
// takes header and payload items on req_ch and emits one line symbol per
// transfer on rsp_ch. a header is sent as a start marker, 2 type cells and
// 32 length cells, followed by the stop marker when the length is zero; a
// payload byte inside an open frame is sent as 8 cells, followed by the
// stop marker when it is the last counted byte; a payload byte with no
// frame open is dropped. the symbol serializer moves one symbol a cycle
// into the output register whenever that register is free or being taken.
// the next item is taken in the same cycle that the last symbol of the
// current one moves to the output register, so items follow each other
// with no gap as long as rsp_ch keeps taking transfers. frame state (open
// flag and bytes left) is updated at the moment an item is accepted.
module framed_manchester_packet_encoder_top (
   input  logic        clock,
   input  logic        reset,
   fmpe_req_if.sink    req_ch,
   fmpe_rsp_if.source  rsp_ch
);

   // frame state
   logic                       frame_open_ff, frame_open_in;
   fmpe_pkg::length_type       bytes_left_ff, bytes_left_in;

   // serializer holding register: one item being turned into symbols
   logic                       hold_valid_ff, hold_valid_in;
   logic                       start_pend_ff, start_pend_in;
   logic                       stop_pend_ff, stop_pend_in;
   fmpe_pkg::cells_type        cells_ff, cells_in;
   fmpe_pkg::cell_cnt_type     cnt_ff, cnt_in;

   // output register
   logic                       out_valid_ff, out_valid_in;
   fmpe_pkg::symbol_type       out_symbol_ff, out_symbol_in;
   logic                       out_last_ff, out_last_in;

   logic                       req_accept;
   logic                       is_header;
   logic                       payload_taken;
   logic                       advance;
   fmpe_pkg::symbol_type       cur_symbol;
   logic                       cur_last;

   // symbol at the head of the serializer
   always_comb begin
      if (start_pend_ff) begin
         cur_symbol = fmpe_pkg::SYM_START;
      end else if (cnt_ff != '0) begin
         cur_symbol = cells_ff[fmpe_pkg::HdrCells-1] ? fmpe_pkg::SYM_ONE
                                                      : fmpe_pkg::SYM_ZERO;
      end else begin
         cur_symbol = fmpe_pkg::SYM_STOP;
      end
   end

   // last symbol of the item: the stop marker, or the final cell with no stop
   assign cur_last = !start_pend_ff &&
                     ((cnt_ff == '0) ||
                      (cnt_ff == fmpe_pkg::CntWidth'(1) && !stop_pend_ff));

   // serializer hands a symbol to the output register when that is free
   assign advance = hold_valid_ff && (!out_valid_ff || rsp_ch.ready);

   // next item may enter as the current one hands over its last symbol
   assign req_ch.ready = !hold_valid_ff || (advance && cur_last);
   assign req_accept   = req_ch.valid && req_ch.ready;
   assign is_header    = (req_ch.kind == fmpe_pkg::KIND_HEADER);
   assign payload_taken = req_accept && !is_header && frame_open_ff;

   // frame state update at acceptance
   always_comb begin
      frame_open_in = frame_open_ff;
      bytes_left_in = bytes_left_ff;
      if (req_accept) begin
         if (is_header) begin
            // a header mid-frame simply restarts the frame
            frame_open_in = (req_ch.payload_length != '0);
            bytes_left_in = req_ch.payload_length;
         end else if (frame_open_ff) begin
            bytes_left_in = bytes_left_ff - fmpe_pkg::LengthWidth'(1);
            if (bytes_left_ff == fmpe_pkg::LengthWidth'(1)) begin
               frame_open_in = 1'b0;
            end
         end
      end
   end

   // serializer next state
   always_comb begin
      hold_valid_in = hold_valid_ff;
      start_pend_in = start_pend_ff;
      stop_pend_in  = stop_pend_ff;
      cells_in      = cells_ff;
      cnt_in        = cnt_ff;
      if (advance) begin
         if (start_pend_ff) begin
            start_pend_in = 1'b0;
         end else if (cnt_ff != '0) begin
            cells_in = {cells_ff[fmpe_pkg::HdrCells-2:0], 1'b0};
            cnt_in   = cnt_ff - fmpe_pkg::CntWidth'(1);
         end else begin
            stop_pend_in = 1'b0;
         end
         if (cur_last) begin
            hold_valid_in = 1'b0;
         end
      end
      if (req_accept) begin
         if (is_header) begin
            hold_valid_in = 1'b1;
            start_pend_in = 1'b1;
            stop_pend_in  = (req_ch.payload_length == '0);
            cells_in      = {req_ch.frame_type, req_ch.payload_length};
            cnt_in        = fmpe_pkg::CntWidth'(fmpe_pkg::HdrCells);
         end else if (payload_taken) begin
            hold_valid_in = 1'b1;
            start_pend_in = 1'b0;
            stop_pend_in  = (bytes_left_ff == fmpe_pkg::LengthWidth'(1));
            cells_in      = {req_ch.payload_byte,
                             {(fmpe_pkg::HdrCells-fmpe_pkg::ByteWidth){1'b0}}};
            cnt_in        = fmpe_pkg::CntWidth'(fmpe_pkg::ByteWidth);
         end
         // a stray payload byte leaves the serializer empty
      end
   end

   // output register: loads on advance, holds while stalled
   always_comb begin
      out_valid_in  = out_valid_ff && !rsp_ch.ready;
      out_symbol_in = out_symbol_ff;
      out_last_in   = out_last_ff;
      if (advance) begin
         out_valid_in  = 1'b1;
         out_symbol_in = cur_symbol;
         out_last_in   = cur_last;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_open_ff <= 1'b0;
         bytes_left_ff <= '0;
         hold_valid_ff <= 1'b0;
         start_pend_ff <= 1'b0;
         stop_pend_ff  <= 1'b0;
         cnt_ff        <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         frame_open_ff <= frame_open_in;
         bytes_left_ff <= bytes_left_in;
         hold_valid_ff <= hold_valid_in;
         start_pend_ff <= start_pend_in;
         stop_pend_ff  <= stop_pend_in;
         cnt_ff        <= cnt_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cells_ff      <= cells_in;
      out_symbol_ff <= out_symbol_in;
      out_last_ff   <= out_last_in;
   end

   assign rsp_ch.valid  = out_valid_ff;
   assign rsp_ch.symbol = out_symbol_ff;
   assign rsp_ch.last   = out_last_ff;

endmodule

// File: rtl/core/fmpe_checker.sv
// port-level assertions of the framed manchester packet encoder and their bind
module fmpe_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          req_kind,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [fmpe_pkg::SymWidth-1:0] rsp_symbol,
   input logic                          rsp_last
);

   // a stalled transfer holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_symbol) && $stable(rsp_last))
      else $error("rsp payload changed while stalled");

   // a start marker always has cells after it
   a_start_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_symbol == fmpe_pkg::SYM_START |-> !rsp_last)
      else $error("start marker flagged last");

   // a stop marker always ends its item
   a_stop_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_symbol == fmpe_pkg::SYM_STOP |-> rsp_last)
      else $error("stop marker not flagged last");

   // a header keeps the block busy for many symbols
   a_header_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_kind == fmpe_pkg::KIND_HEADER |=> !req_ready)
      else $error("item taken right after a header");

   // nothing is shown in the cycle after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("rsp valid right after reset");

endmodule

bind framed_manchester_packet_encoder_top fmpe_checker u_fmpe_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_ch.valid),
   .req_ready  (req_ch.ready),
   .req_kind   (req_ch.kind),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .rsp_symbol (rsp_ch.symbol),
   .rsp_last   (rsp_ch.last)
);
